@@ design/lsu_pkg.sv @@
// lsu_pkg: shared widths and register codes for the level-set stencil update
// no dependencies; imported by level_set_stencil_update
`timescale 1ns / 1ps

package lsu_pkg;

  localparam int VALUE_W   = 32;
  localparam int GAIN_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int SIZE_W    = 11;
  localparam int CLAMP_W   = 13;

  localparam int AX_W      = 32;
  localparam int LAP_W     = 36;
  localparam int ROOT_W    = 33;
  localparam int REM_W     = 35;
  localparam int RAD_W     = 66;
  localparam int DIFF_W    = 37;
  localparam int MAG_W     = 35;
  localparam int PROD_W    = 64;
  localparam int RES_W     = 46;
  localparam int SQRT_STEPS = 33;
  localparam int CNT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd2;

endpackage

@@ design/level_set_stencil_update.sv @@
// level_set_stencil_update: one explicit 2d level-set time step over a raster stream
// a data transaction from the second row on, or a drain in the last row, yields one
// result; in_stall stays high until that result is registered, also while out_stall
// holds it back; the work runs through the 33-step square root and the shared multiplier
// first-row data and empty drains are taken without leaving idle; reset clears counters, gain to 0,
// sizes to 2; row stores are not cleared
`timescale 1ns / 1ps

module level_set_stencil_update
  import lsu_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [VALUE_W-1:0]   in_cell_value,
  input  logic                        in_drain,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VALUE_W-1:0]   out_new_value,
  output logic                        out_last_cell,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data
);

  localparam int CW  = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_MSX, S_MSY, S_ADD, S_ROOT, S_DIFF, S_MGAIN, S_RES
  } state_t;

  state_t state_r;

  logic [GAIN_W-1:0] gain_r;
  logic [CCW-1:0]    cols_r;
  logic [RCW-1:0]    rows_r;
  logic [CW-1:0]     in_col_r, out_col_r;
  logic [RCW-1:0]    in_row_r, out_row_r;

  logic [CW-1:0]              c_r;
  logic signed [VALUE_W-1:0]  v_r, center_r, olda_r;
  logic                       is_data_r, first_row_r;
  logic [AX_W-1:0]            ax_r, ay_r;
  logic signed [LAP_W-1:0]    lap_r;
  logic [PROD_W-1:0]          prod_r, sq_r;
  logic [RAD_W-1:0]           rad_r;
  logic [ROOT_W-1:0]          root_r;
  logic [REM_W-1:0]           rem_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       neg_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       out_valid_r, out_last_r;
  logic signed [VALUE_W-1:0]  out_value_r;

  // row stores
  logic signed [VALUE_W-1:0] mid_mem [MAX_COLUMNS];
  logic signed [VALUE_W-1:0] old_mem [MAX_COLUMNS];
  logic signed [VALUE_W-1:0] mid_q, old_q;
  logic                      mid_we, old_we;
  logic [CW-1:0]             mid_waddr, mid_raddr, old_raddr;
  logic signed [VALUE_W-1:0] mid_wdata;

  always_ff @(posedge clk) begin
    if (mid_we) begin
      mid_mem[mid_waddr] <= mid_wdata;
    end
    mid_q <= mid_mem[mid_raddr];
  end

  always_ff @(posedge clk) begin
    if (old_we) begin
      old_mem[c_r] <= center_r;
    end
    old_q <= old_mem[old_raddr];
  end

  // handshake and decode
  logic accept, data_ok, drain_ok, row0;
  logic in_col_wrap, out_col_wrap, c_first, c_last, out_last_c;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign data_ok   = !in_drain && (in_row_r < rows_r);
  assign drain_ok  = !data_ok && (in_row_r == rows_r) && (out_row_r == rows_r - RCW'(1));
  assign row0      = (in_row_r == '0);
  assign in_col_wrap  = (CCW'(in_col_r) + CCW'(1)) == cols_r;
  assign out_col_wrap = (CCW'(out_col_r) + CCW'(1)) == cols_r;
  assign c_first   = (c_r == '0);
  assign c_last    = (CCW'(c_r) == cols_r - CCW'(1));
  assign out_last_c = (out_row_r == rows_r - RCW'(1)) && out_col_wrap;

  always_comb begin
    mid_we    = 1'b0;
    mid_waddr = c_r;
    mid_wdata = v_r;
    old_we    = 1'b0;
    mid_raddr = c_r;
    old_raddr = c_r;
    if (state_r == S_IDLE) begin
      mid_we    = accept && data_ok && row0;
      mid_waddr = in_col_r;
      mid_wdata = in_cell_value;
    end else if (state_r == S_RD1) begin
      mid_raddr = c_first ? CW'(1) : CW'(c_r + CW'(1));
      old_raddr = CW'(c_r - CW'(1));
    end else if (state_r == S_RD2) begin
      mid_we = is_data_r;
      old_we = 1'b1;
    end
  end

  // stencil taps and first arithmetic
  logic signed [VALUE_W-1:0] left_c, right_c, up_c, down_c;
  logic signed [32:0]        dx_c, dy_c, dxn_c, dyn_c;
  logic [AX_W-1:0]           ax_c, ay_c;
  logic signed [LAP_W-1:0]   lap_c;

  always_comb begin
    left_c  = c_first ? mid_q : old_q;
    right_c = c_last ? old_q : mid_q;
    up_c    = (is_data_r && first_row_r) ? v_r : olda_r;
    down_c  = is_data_r ? v_r : olda_r;
    dx_c    = 33'(right_c) - 33'(left_c);
    dy_c    = 33'(down_c) - 33'(up_c);
    dxn_c   = -dx_c;
    dyn_c   = -dy_c;
    ax_c    = dx_c[32] ? dxn_c[AX_W-1:0] : dx_c[AX_W-1:0];
    ay_c    = dy_c[32] ? dyn_c[AX_W-1:0] : dy_c[AX_W-1:0];
    lap_c   = LAP_W'(left_c) + LAP_W'(right_c) + LAP_W'(up_c) + LAP_W'(down_c)
              - (LAP_W'(center_r) <<< 2);
  end

  // shared multiplier
  logic [AX_W-1:0]         mul_a;
  logic [MAG_W-1:0]        mul_b;
  logic [AX_W+MAG_W-1:0]   mul_p;

  always_comb begin
    unique case (state_r)
      S_MSX: begin
        mul_a = ax_r;
        mul_b = MAG_W'(ax_r);
      end
      S_MSY: begin
        mul_a = ay_r;
        mul_b = MAG_W'(ay_r);
      end
      default: begin
        mul_a = AX_W'(gain_r);
        mul_b = mag_r;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // square root step
  logic [REM_W+1:0] rem_s, trial, rem_sub;
  logic             ge;
  logic [REM_W-1:0] rem_n;

  always_comb begin
    rem_s   = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
    trial   = {2'b00, root_r, 2'b01};
    rem_sub = rem_s - trial;
    ge      = (rem_s >= trial);
    rem_n   = ge ? rem_sub[REM_W-1:0] : rem_s[REM_W-1:0];
  end

  // gain term, rounding and saturation
  logic signed [DIFF_W-1:0] diff_c, diffn_c;
  logic [PROD_W:0]          rnd_c;
  logic [43:0]              m_c;
  logic signed [RES_W-1:0]  delta_c, res_c;
  logic signed [VALUE_W-1:0] sat_c;

  always_comb begin
    diff_c  = $signed({4'b0000, root_r}) - DIFF_W'(lap_r);
    diffn_c = -diff_c;
    rnd_c   = (PROD_W+1)'(prod_r) + (PROD_W+1)'(17'h08000);
    m_c     = rnd_c[59:16];
    delta_c = neg_r ? -$signed({2'b00, m_c}) : $signed({2'b00, m_c});
    res_c   = RES_W'(center_r) - delta_c;
    if (res_c[RES_W-1:VALUE_W-1] != {(RES_W-VALUE_W+1){res_c[RES_W-1]}}) begin
      sat_c = res_c[RES_W-1] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      sat_c = res_c[VALUE_W-1:0];
    end
  end

  // config clamp
  logic [CLAMP_W-1:0] cfg_v, cols_cl, rows_cl;

  always_comb begin
    cfg_v = CLAMP_W'(cfg_data[SIZE_W-1:0]);
    if (cfg_v < CLAMP_W'(2)) begin
      cols_cl = CLAMP_W'(2);
      rows_cl = CLAMP_W'(2);
    end else begin
      cols_cl = (cfg_v > CLAMP_W'(MAX_COLUMNS)) ? CLAMP_W'(MAX_COLUMNS) : cfg_v;
      rows_cl = (cfg_v > CLAMP_W'(MAX_ROWS)) ? CLAMP_W'(MAX_ROWS) : cfg_v;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_value_r;
  assign out_last_cell = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= '0;
      cols_r      <= CCW'(2);
      rows_r      <= RCW'(2);
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_RES) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            v_r         <= in_cell_value;
            first_row_r <= (in_row_r == RCW'(1));
            if (data_ok) begin
              c_r       <= in_col_r;
              is_data_r <= 1'b1;
              if (in_col_wrap) begin
                in_col_r <= '0;
                in_row_r <= in_row_r + RCW'(1);
              end else begin
                in_col_r <= in_col_r + CW'(1);
              end
              if (!row0) begin
                state_r <= S_RD0;
              end
            end else if (drain_ok) begin
              c_r       <= out_col_r;
              is_data_r <= 1'b0;
              state_r   <= S_RD0;
            end
          end
        end
        S_RD0: begin
          state_r <= S_RD1;
        end
        S_RD1: begin
          center_r <= mid_q;
          olda_r   <= old_q;
          state_r  <= S_RD2;
        end
        S_RD2: begin
          ax_r    <= ax_c;
          ay_r    <= ay_c;
          lap_r   <= lap_c;
          state_r <= S_MSX;
        end
        S_MSX: begin
          prod_r  <= mul_p[PROD_W-1:0];
          state_r <= S_MSY;
        end
        S_MSY: begin
          sq_r    <= prod_r;
          prod_r  <= mul_p[PROD_W-1:0];
          state_r <= S_ADD;
        end
        S_ADD: begin
          rad_r   <= {1'b0, {1'b0, sq_r} + {1'b0, prod_r}};
          root_r  <= '0;
          rem_r   <= '0;
          cnt_r   <= CNT_W'(SQRT_STEPS - 1);
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          rem_r  <= rem_n;
          root_r <= {root_r[ROOT_W-2:0], ge};
          rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
          cnt_r  <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          neg_r   <= diff_c[DIFF_W-1];
          mag_r   <= diff_c[DIFF_W-1] ? diffn_c[MAG_W-1:0] : diff_c[MAG_W-1:0];
          state_r <= S_MGAIN;
        end
        S_MGAIN: begin
          prod_r  <= mul_p[PROD_W-1:0];
          state_r <= S_RES;
        end
        S_RES: begin
          if (!(out_valid_r && out_stall)) begin
            out_valid_r <= 1'b1;
            out_value_r <= sat_c;
            out_last_r  <= out_last_c;
            if (out_last_c) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
            end else if (out_col_wrap) begin
              out_col_r <= '0;
              out_row_r <= out_row_r + RCW'(1);
            end else begin
              out_col_r <= out_col_r + CW'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP_GAIN: begin
            gain_r <= cfg_data[GAIN_W-1:0];
          end
          CFG_GRID_COLUMNS: begin
            cols_r    <= CCW'(cols_cl);
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
          end
          CFG_GRID_ROWS: begin
            rows_r    <= RCW'(rows_cl);
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
